// ===== design/tube_profile_interp_window_top_assert.svh =====
// assertion macros for the corridor profile table
`ifndef TUBE_PROFILE_INTERP_WINDOW_TOP_ASSERT_SVH
`define TUBE_PROFILE_INTERP_WINDOW_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define TPIW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TPIW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tpiw_pkg.sv =====
// ----------------------------------------------------------------------------
// tpiw_pkg
// types and constants shared by the corridor profile table modules
// ----------------------------------------------------------------------------
`default_nettype none

package tpiw_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_POINT  = 2'd2;
    localparam logic [1:0] CMD_WINDOW = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic [16:0] OPEN_ONE = 17'd65536;

    localparam int FRAC_BITS = 30;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 16;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic signed [31:0] lower_slope;
        logic signed [31:0] upper_slope;
        logic [16:0]        openness;
        logic signed [31:0] regularity;
        logic               certified;
    } t_sample;

endpackage

`default_nettype wire

// ===== design/tube_profile_interp_window_top.sv =====
// Corridor profile table with piecewise linear interpolation.
// Input channel (i_in_valid / o_in_ready) takes one command per transaction:
// clear, load sample, point query or window query. Output channel
// (o_out_valid / i_out_ready) returns one result per query, none for clear
// or load. Clear and load complete without leaving the idle state. With n
// samples loaded, a point query runs three setup steps, a scan of the
// sample memory one entry per cycle (one read port, at most n - 1 entries),
// a select step, a bit-serial divide for the fraction when it is neither
// zero nor one, then the shared multiplier for five interpolations and an
// output step. A window query scans all n entries and then a finish step,
// unless its clipped window is empty. A query with fewer than two samples
// goes straight to the output step. The block takes a new transaction only
// when idle, in the cycle after the previous result is loaded. A finished
// result waits in the output register while the receiver stalls; the next
// query holds in its last step until that register frees. Reset empties the
// table and sets the running minimum regularity to one; the sample memory
// itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// tube_profile_interp_window_top
// sample memory, sequencer and datapath of the corridor profile table
// ----------------------------------------------------------------------------
`default_nettype none

`include "tube_profile_interp_window_top_assert.svh"

module tube_profile_interp_window_top
    import tpiw_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [31:0] i_pos,
    input  wire logic signed [31:0] i_window_end,
    input  wire logic signed [31:0] i_lower_offset,
    input  wire logic signed [31:0] i_upper_offset,
    input  wire logic signed [31:0] i_lower_slope,
    input  wire logic signed [31:0] i_upper_slope,
    input  wire logic [16:0]        i_openness,
    input  wire logic signed [31:0] i_regularity,
    input  wire logic               i_certified,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_pos,
    output logic signed [31:0]      o_result_lower,
    output logic signed [31:0]      o_result_upper,
    output logic signed [31:0]      o_result_lower_slope,
    output logic signed [31:0]      o_result_upper_slope,
    output logic [16:0]             o_result_openness,
    output logic signed [31:0]      o_result_min_regularity
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P0   = 4'd1;
    localparam logic [3:0] S_P1   = 4'd2;
    localparam logic [3:0] S_PL   = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_WFIN = 4'd5;
    localparam logic [3:0] S_SEL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_M0   = 4'd8;
    localparam logic [3:0] S_M1   = 4'd9;
    localparam logic [3:0] S_M2   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    t_sample r_mem [MAX_SAMPLES];
    t_sample r_rd, r_prev, r_e0, r_e1, r_a, r_b, wr_sample;

    logic [3:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_i;
    logic [AW-1:0]      r_raddr;
    logic signed [31:0] r_runmin;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_qpos, r_qend;
    logic signed [31:0] r_wc, r_a0, r_a1;
    logic signed [31:0] r_lo, r_up, r_mr;
    logic [16:0]        r_op;
    logic               r_any;
    logic [30:0]        r_s;
    logic [2:0]         r_f;
    logic [63:0]        r_acc;
    logic [1:0]         r_status;
    logic signed [31:0] r_res_pos, r_res_lo, r_res_up, r_res_ls, r_res_us, r_res_mr;
    logic [16:0]        r_res_op;

    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic signed [31:0] r_o_pos, r_o_lo, r_o_up, r_o_ls, r_o_us, r_o_mr;
    logic [16:0]        r_o_op;

    logic               in_acc, out_free, is_point, last_i, in_win;
    logic [CW-1:0]      n_last;
    logic signed [31:0] p1, wc_c, a0_c, a1_c;
    logic signed [32:0] t_c, d_c;
    logic               div_start, div_done;
    logic [FRAC_BITS-1:0] div_quot;
    logic signed [32:0] fv_a, fv_b;
    logic signed [33:0] diff;
    logic               neg;
    logic [32:0]        mag;
    logic [15:0]        mul_b;
    logic [48:0]        mul_p;
    logic [63:0]        full, full_rnd;
    logic signed [33:0] interp;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign is_point = r_cmd == CMD_POINT;
    assign n_last   = r_count - CW'(1);
    assign last_i   = r_i == n_last;

    assign wr_sample = '{pos: i_pos, lower: i_lower_offset, upper: i_upper_offset,
                         lower_slope: i_lower_slope, upper_slope: i_upper_slope,
                         openness: i_openness, regularity: i_regularity,
                         certified: i_certified};

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_LOAD && r_count < CW'(MAX_SAMPLES)) begin
            r_mem[r_count[AW-1:0]] <= wr_sample;
        end
        r_rd <= r_mem[r_raddr];
    end

    assign p1   = r_rd.pos;
    assign wc_c = (r_qpos < p1) ? ((r_qpos < r_e0.pos) ? r_e0.pos : r_qpos)
                                : ((p1 < r_e0.pos) ? r_e0.pos : p1);
    assign a0_c = (r_qpos > r_e0.pos) ? r_qpos : r_e0.pos;
    assign a1_c = (r_qend < p1) ? r_qend : p1;
    assign in_win = r_rd.certified && r_rd.pos >= r_a0 && r_rd.pos <= r_a1;

    assign t_c = {r_wc[31], r_wc} - {r_a.pos[31], r_a.pos};
    assign d_c = {r_b.pos[31], r_b.pos} - {r_a.pos[31], r_a.pos};
    assign div_start = r_state == S_SEL && d_c > 0 && t_c > 0 && t_c < d_c;

    tpiw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (t_c),
        .i_den   (d_c),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        case (r_f)
            3'd0: begin
                fv_a = {r_a.lower[31], r_a.lower};
                fv_b = {r_b.lower[31], r_b.lower};
            end
            3'd1: begin
                fv_a = {r_a.upper[31], r_a.upper};
                fv_b = {r_b.upper[31], r_b.upper};
            end
            3'd2: begin
                fv_a = {r_a.lower_slope[31], r_a.lower_slope};
                fv_b = {r_b.lower_slope[31], r_b.lower_slope};
            end
            3'd3: begin
                fv_a = {r_a.upper_slope[31], r_a.upper_slope};
                fv_b = {r_b.upper_slope[31], r_b.upper_slope};
            end
            default: begin
                fv_a = {16'd0, r_a.openness};
                fv_b = {16'd0, r_b.openness};
            end
        endcase
    end

    assign diff  = {fv_b[32], fv_b} - {fv_a[32], fv_a};
    assign neg   = diff[33];
    assign mag   = neg ? 33'(-diff) : diff[32:0];
    assign mul_b = (r_state == S_M1) ? r_s[30:15] : {1'b0, r_s[14:0]};

    tpiw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mag),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign full     = r_acc + {mul_p, 15'd0};
    assign full_rnd = full + 64'(1 << 29);
    assign interp   = {fv_a[32], fv_a} + (neg ? -$signed({1'b0, full_rnd[62:30]})
                                              : $signed({1'b0, full_rnd[62:30]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_runmin  <= Q_ONE;
            r_raddr   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_command)
                            CMD_CLEAR: begin
                                r_count  <= '0;
                                r_runmin <= Q_ONE;
                            end
                            CMD_LOAD: begin
                                if (r_count < CW'(MAX_SAMPLES)) begin
                                    r_count <= r_count + CW'(1);
                                    if (i_regularity < r_runmin) begin
                                        r_runmin <= i_regularity;
                                    end
                                end
                            end
                            default: begin
                                r_raddr <= '0;
                                if (r_count < CW'(2)) begin
                                    r_status <= ST_FEW;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_P0;
                                end
                            end
                        endcase
                    end
                end
                S_P0: begin
                    r_raddr <= n_last[AW-1:0];
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_e0    <= r_rd;
                    r_prev  <= r_rd;
                    r_raddr <= is_point ? AW'(1) : AW'(0);
                    r_state <= S_PL;
                end
                S_PL: begin
                    r_i     <= is_point ? CW'(1) : CW'(0);
                    r_raddr <= is_point ? AW'(2) : AW'(1);
                    r_wc    <= wc_c;
                    r_a0    <= a0_c;
                    r_a1    <= a1_c;
                    r_lo    <= '0;
                    r_up    <= '0;
                    r_op    <= OPEN_ONE;
                    r_mr    <= Q_ONE;
                    r_any   <= 1'b0;
                    if (!is_point && a1_c < a0_c) begin
                        r_status <= ST_FAIL;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_i     <= r_i + CW'(1);
                    r_raddr <= r_raddr + AW'(1);
                    if (is_point) begin
                        r_prev <= r_rd;
                        if (r_i == CW'(1)) begin
                            r_e1 <= r_rd;
                        end
                        if (r_rd.pos >= r_wc) begin
                            r_a     <= r_prev;
                            r_b     <= r_rd;
                            r_state <= S_SEL;
                        end else if (last_i) begin
                            r_a     <= r_e0;
                            r_b     <= (r_i == CW'(1)) ? r_rd : r_e1;
                            r_state <= S_SEL;
                        end
                    end else begin
                        if (in_win) begin
                            if (!r_any || r_rd.lower > r_lo) begin
                                r_lo <= r_rd.lower;
                            end
                            if (!r_any || r_rd.upper < r_up) begin
                                r_up <= r_rd.upper;
                            end
                            if (r_rd.openness < r_op) begin
                                r_op <= r_rd.openness;
                            end
                            if (r_rd.regularity < r_mr) begin
                                r_mr <= r_rd.regularity;
                            end
                            r_any <= 1'b1;
                        end
                        if (last_i) begin
                            r_state <= S_WFIN;
                        end
                    end
                end
                S_WFIN: begin
                    r_res_pos <= r_a0;
                    r_res_lo  <= r_lo;
                    r_res_up  <= r_up;
                    r_res_ls  <= '0;
                    r_res_us  <= '0;
                    r_res_op  <= r_op;
                    r_res_mr  <= r_mr;
                    r_status  <= (!r_any || r_lo > r_up) ? ST_FAIL : ST_OK;
                    r_state   <= S_OUT;
                end
                S_SEL: begin
                    r_f <= '0;
                    if (d_c <= 0 || t_c <= 0) begin
                        r_s     <= '0;
                        r_state <= S_M0;
                    end else if (t_c >= d_c) begin
                        r_s     <= 31'(1 << FRAC_BITS);
                        r_state <= S_M0;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_s     <= {1'b0, div_quot};
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= 64'(mul_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    case (r_f)
                        3'd0:    r_res_lo <= interp[31:0];
                        3'd1:    r_res_up <= interp[31:0];
                        3'd2:    r_res_ls <= interp[31:0];
                        3'd3:    r_res_us <= interp[31:0];
                        default: r_res_op <= interp[16:0];
                    endcase
                    if (r_f == 3'd4) begin
                        r_res_pos <= r_wc;
                        r_res_mr  <= r_runmin;
                        r_status  <= ST_OK;
                        r_state   <= S_OUT;
                    end else begin
                        r_f     <= r_f + 3'd1;
                        r_state <= S_M0;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_command;
            r_qpos <= i_pos;
            r_qend <= i_window_end;
        end
        if (r_state == S_OUT && out_free) begin
            r_o_status <= r_status;
            if (r_status == ST_OK) begin
                r_o_pos <= r_res_pos;
                r_o_lo  <= r_res_lo;
                r_o_up  <= r_res_up;
                r_o_ls  <= r_res_ls;
                r_o_us  <= r_res_us;
                r_o_op  <= r_res_op;
                r_o_mr  <= r_res_mr;
            end else begin
                r_o_pos <= '0;
                r_o_lo  <= '0;
                r_o_up  <= '0;
                r_o_ls  <= '0;
                r_o_us  <= '0;
                r_o_op  <= '0;
                r_o_mr  <= '0;
            end
        end
    end

    assign o_in_ready              = r_state == S_IDLE;
    assign o_out_valid             = r_o_valid;
    assign o_status                = r_o_status;
    assign o_result_pos            = r_o_pos;
    assign o_result_lower          = r_o_lo;
    assign o_result_upper          = r_o_up;
    assign o_result_lower_slope    = r_o_ls;
    assign o_result_upper_slope    = r_o_us;
    assign o_result_openness       = r_o_op;
    assign o_result_min_regularity = r_o_mr;

    `TPIW_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_SAMPLES), "count over max")
    `TPIW_ASSERT_SAME(a_minreg_cap, i_clk, i_rst_n, o_out_valid, o_result_min_regularity <= Q_ONE, "min regularity above one")
    `TPIW_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == S_OUT && out_free, o_out_valid, "result not presented")
    `TPIW_ASSERT_SAME(a_frac_range, i_clk, i_rst_n, r_state == S_M0, r_s <= 31'(1 << FRAC_BITS), "fraction above one")

endmodule

`default_nettype wire

// ===== design/tpiw_div.sv =====
// ----------------------------------------------------------------------------
// tpiw_div
// restoring divider, one quotient bit per cycle, fraction num/den in Q0.30
// ----------------------------------------------------------------------------
`default_nettype none

module tpiw_div
    import tpiw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [32:0]          i_num,
    input  wire logic [32:0]          i_den,
    output logic                      o_done,
    output logic [FRAC_BITS-1:0]      o_quot
);

    logic [32:0]          r_rem;
    logic [32:0]          r_den;
    logic [FRAC_BITS-1:0] r_quot;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [33:0]          rem_sh;
    logic [33:0]          rem_sub;
    logic                 take;

    assign rem_sh  = {r_rem, 1'b0};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign take    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? rem_sub[32:0] : rem_sh[32:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== design/tpiw_mul.sv =====
// ----------------------------------------------------------------------------
// tpiw_mul
// shared 33 x 16 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module tpiw_mul
    import tpiw_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic [MUL_A_W-1:0]           i_a,
    input  wire logic [MUL_B_W-1:0]           i_b,
    output logic      [MUL_A_W+MUL_B_W-1:0]   o_p
);

    logic [MUL_A_W+MUL_B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (MUL_A_W+MUL_B_W)'(i_a) * (MUL_A_W+MUL_B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire
